// File: sv/tlc_pkg.sv
`default_nettype none
package tlc_pkg;
  localparam int ENTRIES_DEF   = 32;
  localparam int TILE_ROWS_DEF = 1024;
  localparam int ROW_MARGIN_DEF = 64;
  localparam int WIDTH_LIMIT   = 8192;
  localparam logic [13:0] ROW_WIDTH_RST   = 14'd1024;
  localparam logic [5:0]  MAX_TILES_RST   = 6'd24;
  localparam logic [30:0] BYTE_BUDGET_RST = 31'd167772160;
  localparam logic [30:0] BYTES_CAP       = 31'h7FFF_FFFF;

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_INVAL  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] EV_HIT   = 3'd0;
  localparam logic [2:0] EV_MISS  = 3'd1;
  localparam logic [2:0] EV_EVICT = 3'd2;
  localparam logic [2:0] EV_INVAL = 3'd3;
  localparam logic [2:0] EV_DONE  = 3'd4;

  localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
  localparam logic [1:0] REG_MAX_TILES   = 2'd1;
  localparam logic [1:0] REG_BYTE_BUDGET = 2'd2;
endpackage
`default_nettype wire

// File: sv/tile_lru_cache_with_byte_budget.sv
`default_nettype none
// Tile LRU cache with byte budget.
// Input channel (in_valid/in_stall): one transfer carries a command: access a
// tile, invalidate a row range, or clear. Output channel (out_valid/out_stall):
// each command yields one or more result transfers, the final one with last=1.
// Access: optional eviction for room, then hit/miss event, then end-of-frame
// budget evictions. Invalidate: one event per removed tile, then done.
// All work runs through one sequencer that visits the ENTRIES slots one per
// cycle, pausing in an invalidate to emit each removed tile: the tag match,
// the free-slot search, the LRU age compare and the invalidate range test all
// share that single slot walk. An access walks (S_SCAN), decides (S_DEC) and
// emits (S_EMIT); a room eviction repeats S_EMIT and S_DEC, each end-of-frame
// eviction walks again (S_AGE). A clear, an unknown command, a bad width or
// an empty range goes straight to S_EMIT; an invalidate walks (S_INV), then
// emits done (S_FIN). The row-range bounds use arithmetic shifts (TILE_ROWS
// is a power of two). in_stall is high while a command is in progress or a
// result waits; the next command is taken the cycle after the final result
// transfer. A stalled result stays in the output register and S_EMIT waits;
// nothing is lost. Reset (rst, synchronous) empties the store, zeroes the
// use counter, byte total and frame counts, and loads the register defaults.
module tile_lru_cache_with_byte_budget #(
  parameter int ENTRIES    = tlc_pkg::ENTRIES_DEF,
  parameter int TILE_ROWS  = tlc_pkg::TILE_ROWS_DEF,
  parameter int ROW_MARGIN = tlc_pkg::ROW_MARGIN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [13:0] tile_num,
  input  wire logic        first_of_frame,
  input  wire logic        end_of_frame,
  input  wire logic signed [24:0] top_row,
  input  wire logic signed [24:0] bottom_row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_res,
  output logic [13:0]      event_tile,
  output logic [5:0]       tiles_held,
  output logic [30:0]      bytes_held,
  output logic [15:0]      frame_hits,
  output logic [15:0]      frame_misses,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tlc_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int TSH = $clog2(TILE_ROWS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,  // match / free / oldest walk
    S_DEC   = 7'b0000100,
    S_AGE   = 7'b0001000,  // oldest walk for end-of-frame
    S_EMIT  = 7'b0010000,
    S_INV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    P_ROOM = 2'd0, P_INS = 2'd1, P_EOF = 2'd2, P_INV = 2'd3
  } phase_t;

  state_t state;
  phase_t phase;

  logic [13:0] row_width;
  logic [5:0]  max_tiles;
  logic [30:0] byte_budget;

  logic [ENTRIES-1:0] entry_valid;
  logic [13:0] entry_tile  [ENTRIES];
  logic [31:0] entry_stamp [ENTRIES];
  logic [31:0] use_counter;
  logic [30:0] bytes_total;
  logic [15:0] hit_count, miss_count;
  logic [CW-1:0] held;

  logic [13:0] tile_r;
  logic        eof_r;
  logic [24:0] inv_first, inv_last;

  logic [SW-1:0] idx, ins_slot, hit_slot, free_slot, best_slot;
  logic          hit_f, free_f, best_f;
  logic [31:0]   best_age;
  logic          idx_end;

  // event to present after S_EMIT
  logic [2:0]  ev_code;
  logic [13:0] ev_tile;
  logic        ev_last;
  logic        ev_trim;   // hit/miss or trim eviction: final unless trim goes on

  // tile cost = row_width * 4 * TILE_ROWS
  logic [31:0] cost;
  assign cost = 32'(row_width) << (2 + TSH);

  logic [31:0] age_i;
  assign age_i = use_counter - entry_stamp[idx];
  assign idx_end = (idx == SW'(ENTRIES - 1));

  logic width_bad;
  assign width_bad = (row_width == 14'd0) || (row_width > 14'(WIDTH_LIMIT));

  logic over_budget;
  assign over_budget = (32'(held) > 32'(max_tiles)) || (bytes_total > byte_budget);

  // another end-of-frame eviction follows: over budget and a tile other than
  // the one just touched is still held
  logic trim_more, emit_last;
  assign trim_more = eof_r && over_budget && (held > CW'(1));
  assign emit_last = ev_trim ? !trim_more : ev_last;

  logic [31:0] sub_b, add_b;
  assign sub_b = (32'(bytes_total) >= cost) ? 32'(bytes_total) - cost : 32'd0;
  assign add_b = 32'(bytes_total) + cost;

  // invalidate bounds
  logic signed [25:0] t_m, b_m;
  logic signed [25:0] f_d, l_d;
  assign t_m = 26'(signed'(top_row)) - 26'(ROW_MARGIN);
  assign b_m = 26'(signed'(bottom_row)) + 26'(ROW_MARGIN) - 26'sd1;
  assign f_d = t_m >>> TSH;
  assign l_d = b_m >>> TSH;

  logic in_range;
  assign in_range = entry_valid[idx] &&
                    ($signed({11'd0, entry_tile[idx]}) >= $signed(inv_first)) &&
                    ($signed({11'd0, entry_tile[idx]}) <= $signed(inv_last));

  assign in_stall = (state != S_IDLE) || out_valid;
  assign pready = 1'b1;

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      REG_ROW_WIDTH:   prdata = 32'(row_width);
      REG_MAX_TILES:   prdata = 32'(max_tiles);
      REG_BYTE_BUDGET: prdata = 32'(byte_budget);
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RST;
      max_tiles <= MAX_TILES_RST;
      byte_budget <= BYTE_BUDGET_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_ROW_WIDTH:   row_width <= pwdata[13:0];
        REG_MAX_TILES:   max_tiles <= pwdata[5:0];
        REG_BYTE_BUDGET: byte_budget <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // sequencer, cache store, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_ROOM;
      out_valid <= 1'b0;
      entry_valid <= '0;
      use_counter <= '0;
      bytes_total <= '0;
      hit_count <= '0;
      miss_count <= '0;
      held <= '0;
    end else begin
      // S_EMIT reloads the output register itself
      if (out_valid && !out_stall && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            tile_r <= tile_num;
            eof_r <= end_of_frame;
            inv_first <= (f_d < 0) ? 25'd0 : f_d[24:0];
            inv_last  <= (l_d < ((f_d < 0) ? 26'sd0 : f_d)) ?
                         ((f_d < 0) ? 25'd0 : f_d[24:0]) : l_d[24:0];
            idx <= '0;
            hit_f <= 1'b0; free_f <= 1'b0; best_f <= 1'b0;
            ev_trim <= 1'b0;
            if (command == CMD_ACCESS && !width_bad) begin
              if (first_of_frame) begin
                hit_count <= '0; miss_count <= '0;
              end
              phase <= P_ROOM;
              state <= S_SCAN;
            end else if (command == CMD_INVAL) begin
              if (bottom_row > top_row) begin
                phase <= P_INV;
                state <= S_INV;
              end else begin
                ev_code <= EV_DONE; ev_tile <= '0; ev_last <= 1'b1;
                state <= S_EMIT;
              end
            end else begin
              if (command == CMD_CLEAR) begin
                entry_valid <= '0; held <= '0; bytes_total <= '0;
                hit_count <= '0; miss_count <= '0;
              end
              ev_code <= EV_DONE; ev_tile <= '0; ev_last <= 1'b1;
              state <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          if (entry_valid[idx] && entry_tile[idx] == tile_r && !hit_f) begin
            hit_f <= 1'b1; hit_slot <= idx;
          end
          if (!entry_valid[idx] && !free_f) begin
            free_f <= 1'b1; free_slot <= idx;
          end
          if (entry_valid[idx] && (!best_f || age_i > best_age)) begin
            best_f <= 1'b1; best_slot <= idx; best_age <= age_i;
          end
          if (idx_end) state <= S_DEC;
          else idx <= idx + 1'b1;
        end
        S_DEC: begin
          // decide after a full walk or a room eviction (phase room/insert or end-of-frame)
          if (phase == P_EOF) begin
            if (best_f && over_budget) begin
              entry_valid[best_slot] <= 1'b0;
              held <= held - 1'b1;
              bytes_total <= sub_b[30:0];
              ev_code <= EV_EVICT; ev_tile <= entry_tile[best_slot];
              ev_last <= 1'b0; ev_trim <= 1'b1;
              state <= S_EMIT;
            end else begin
              state <= S_FIN;
            end
          end else if (hit_f) begin
            if (hit_count != 16'hFFFF) hit_count <= hit_count + 1'b1;
            entry_stamp[hit_slot] <= use_counter;
            use_counter <= use_counter + 1'b1;
            ins_slot <= hit_slot;
            ev_code <= EV_HIT; ev_tile <= tile_r; ev_last <= 1'b0; ev_trim <= 1'b1;
            phase <= P_INS;
            state <= S_EMIT;
          end else if (free_f || phase == P_INS) begin
            // miss already counted when room was made
            if (phase == P_ROOM && miss_count != 16'hFFFF) miss_count <= miss_count + 1'b1;
            entry_valid[free_f ? free_slot : best_slot] <= 1'b1;
            entry_tile[free_f ? free_slot : best_slot] <= tile_r;
            entry_stamp[free_f ? free_slot : best_slot] <= use_counter;
            ins_slot <= free_f ? free_slot : best_slot;
            use_counter <= use_counter + 1'b1;
            held <= held + 1'b1;
            bytes_total <= (add_b > 32'(BYTES_CAP)) ? BYTES_CAP : add_b[30:0];
            ev_code <= EV_MISS; ev_tile <= tile_r; ev_last <= 1'b0; ev_trim <= 1'b1;
            phase <= P_INS;
            state <= S_EMIT;
          end else begin
            // full store: evict oldest for room, slot reused by insert
            if (miss_count != 16'hFFFF) miss_count <= miss_count + 1'b1;
            entry_valid[best_slot] <= 1'b0;
            held <= held - 1'b1;
            bytes_total <= sub_b[30:0];
            ev_code <= EV_EVICT; ev_tile <= entry_tile[best_slot];
            ev_last <= 1'b0; ev_trim <= 1'b0;
            phase <= P_INS;
            state <= S_EMIT;
          end
        end
        S_AGE: begin
          if (entry_valid[idx] && idx != ins_slot &&
              (!best_f || age_i > best_age)) begin
            best_f <= 1'b1; best_slot <= idx; best_age <= age_i;
          end
          if (idx_end) state <= S_DEC;
          else idx <= idx + 1'b1;
        end
        S_INV: begin
          if (in_range) begin
            entry_valid[idx] <= 1'b0;
            held <= held - 1'b1;
            bytes_total <= sub_b[30:0];
            ev_code <= EV_INVAL; ev_tile <= entry_tile[idx]; ev_last <= 1'b0;
            state <= S_EMIT;
          end else if (idx_end) begin
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            event_res <= ev_code;
            event_tile <= ev_tile;
            tiles_held <= 6'(held);
            bytes_held <= bytes_total;
            frame_hits <= hit_count;
            frame_misses <= miss_count;
            last <= emit_last;
            if (emit_last) begin
              state <= S_IDLE;
            end else if (phase == P_INV) begin
              if (idx_end) state <= S_FIN;
              else begin
                idx <= idx + 1'b1;
                state <= S_INV;
              end
            end else if (phase == P_INS && ev_code == EV_EVICT) begin
              // room made: insert into freed slot
              free_f <= 1'b1; free_slot <= best_slot; hit_f <= 1'b0;
              state <= S_DEC;
            end else begin
              // end-of-frame evictions
              phase <= P_EOF;
              idx <= '0; best_f <= 1'b0;
              state <= S_AGE;
            end
          end
        end
        S_FIN: begin
          ev_code <= EV_DONE; ev_tile <= '0; ev_last <= 1'b1; ev_trim <= 1'b0;
          state <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/tlc_checker.sv
`default_nettype none
module tlc_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [5:0] tiles_held,
  input wire logic last,
  input wire logic [2:0] event_res
);
  import tlc_pkg::*;

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped under stall");

  property p_busy;
    @(posedge clk) disable iff (rst) out_valid |-> in_stall;
  endproperty
  a_busy: assert property (p_busy) else $error("input taken with result pending");

  property p_done_last;
    @(posedge clk) disable iff (rst) out_valid && event_res == EV_DONE |-> last;
  endproperty
  a_done: assert property (p_done_last) else $error("done without last");

  property p_cap;
    @(posedge clk) disable iff (rst) out_valid |-> tiles_held <= 6'(ENTRIES_DEF);
  endproperty
  a_cap: assert property (p_cap) else $error("tile count out of range");
endmodule

bind tile_lru_cache_with_byte_budget tlc_checker u_tlc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .tiles_held(tiles_held),
  .last(last), .event_res(event_res)
);
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tlc_pkg::*;

  // Geometry of the instance under test
  localparam int NSLOT = 32;
  localparam int TROWS = 1024;
  localparam int MARGIN = 64;
  localparam int LIMIT_CYCLES = 2000000;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = CMD_ACCESS;
  logic [13:0] tile_num = '0;
  logic first_of_frame = 1'b0;
  logic end_of_frame = 1'b0;
  logic signed [24:0] top_row = '0;
  logic signed [24:0] bottom_row = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] event_res;
  logic [13:0] event_tile;
  logic [5:0] tiles_held;
  logic [30:0] bytes_held;
  logic [15:0] frame_hits;
  logic [15:0] frame_misses;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tile_lru_cache_with_byte_budget dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  typedef struct packed {
    logic [2:0] ev;
    logic [13:0] tile;
    logic [5:0] held;
    logic [30:0] bytes;
    logic [15:0] hits;
    logic [15:0] misses;
    logic last;
  } event_t;

  typedef struct {
    logic [1:0] cmd;
    logic [13:0] tile;
    logic first;
    logic endf;
    logic signed [24:0] top;
    logic signed [24:0] bot;
  } cmd_t;

  // Shadow copy of the cache state used to predict result transfers
  logic [13:0] sh_width;
  logic [5:0] sh_max;
  logic [30:0] sh_budget;
  logic sh_valid [NSLOT];
  logic [13:0] sh_tile [NSLOT];
  logic [31:0] sh_stamp [NSLOT];
  logic [31:0] sh_use;
  logic [30:0] sh_bytes;
  logic [15:0] sh_hits, sh_misses;

  event_t pending_events[$];
  int errors = 0;
  int cycles = 0;
  int pred_base = 0;   // queue position of the first result of the last command
  bit quiet = 0;   // last part of the run: no idling on either side

  function automatic string fmt_ev(event_t e);
    return $sformatf("ev=%0d tile=%0d held=%0d bytes=%0d h=%0d m=%0d l=%0d",
                     e.ev, e.tile, e.held, e.bytes, e.hits, e.misses, e.last);
  endfunction

  task automatic report(input string what, input event_t got, input event_t want);
    errors++;
    $display("mismatch %s: got %s, want %s", what, fmt_ev(got), fmt_ev(want));
  endtask

  function automatic int count_held();
    int n = 0;
    for (int i = 0; i < NSLOT; i++) n += sh_valid[i];
    return n;
  endfunction

  function automatic longint tile_bytes();
    return longint'(sh_width) * 4 * TROWS;
  endfunction

  function automatic void push_event(logic [2:0] ev, logic [13:0] t);
    event_t e;
    e.ev = ev; e.tile = t; e.held = 6'(count_held()); e.bytes = sh_bytes;
    e.hits = sh_hits; e.misses = sh_misses; e.last = 1'b0;
    pending_events.push_back(e);
  endfunction

  function automatic void drop_slot(int i, logic [2:0] ev);
    longint c = tile_bytes();
    sh_valid[i] = 1'b0;
    sh_bytes = (longint'(sh_bytes) >= c) ? 31'(longint'(sh_bytes) - c) : '0;
    push_event(ev, sh_tile[i]);
  endfunction

  function automatic int lru_slot(int skip);
    int best = -1;
    logic [31:0] best_age = '0;
    logic [31:0] age;
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_valid[i] && i != skip) begin
        age = sh_use - sh_stamp[i];
        if (best < 0 || age > best_age) begin
          best = i; best_age = age;
        end
      end
    end
    return best;
  endfunction

  function automatic longint floor_by_rows(longint a);
    longint q = a / TROWS;
    if ((a % TROWS) != 0 && a < 0) q--;
    return q;
  endfunction

  // Predict all result transfers of one command, last flag set on the final one
  function automatic void predict_command(cmd_t c);
    int slot = -1;
    longint lo, hi, s;
    int n0 = pending_events.size();
    case (c.cmd)
      CMD_ACCESS: begin
        if (sh_width == 0 || sh_width > WIDTH_LIMIT) begin
          push_event(EV_DONE, '0);
        end else begin
          if (c.first) begin
            sh_hits = '0; sh_misses = '0;
          end
          for (int i = 0; i < NSLOT; i++)
            if (slot < 0 && sh_valid[i] && sh_tile[i] == c.tile) slot = i;
          if (slot >= 0) begin
            if (sh_hits != 16'hFFFF) sh_hits++;
            sh_stamp[slot] = sh_use++;
            push_event(EV_HIT, c.tile);
          end else begin
            if (sh_misses != 16'hFFFF) sh_misses++;
            for (int i = 0; i < NSLOT; i++)
              if (slot < 0 && !sh_valid[i]) slot = i;
            if (slot < 0) begin
              slot = lru_slot(-1);
              drop_slot(slot, EV_EVICT);
            end
            sh_valid[slot] = 1'b1;
            sh_tile[slot] = c.tile;
            sh_stamp[slot] = sh_use++;
            s = longint'(sh_bytes) + tile_bytes();
            sh_bytes = (s > longint'(BYTES_CAP)) ? BYTES_CAP : 31'(s);
            push_event(EV_MISS, c.tile);
          end
          // end-of-frame trim never removes the tile just touched
          if (c.endf) begin
            while (count_held() > sh_max || sh_bytes > sh_budget) begin
              int v = lru_slot(slot);
              if (v < 0) break;
              drop_slot(v, EV_EVICT);
            end
          end
        end
      end
      CMD_INVAL: begin
        if (c.bot > c.top) begin
          lo = floor_by_rows(longint'(c.top) - MARGIN);
          hi = floor_by_rows(longint'(c.bot) + MARGIN - 1);
          if (lo < 0) lo = 0;
          if (hi < lo) hi = lo;
          for (int i = 0; i < NSLOT; i++)
            if (sh_valid[i] && longint'(sh_tile[i]) >= lo && longint'(sh_tile[i]) <= hi)
              drop_slot(i, EV_INVAL);
        end
        push_event(EV_DONE, '0);
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
        sh_bytes = '0; sh_hits = '0; sh_misses = '0;
        push_event(EV_DONE, '0);
      end
      default: push_event(EV_DONE, '0);
    endcase
    if (pending_events.size() > n0) pending_events[$].last = 1'b1;
  endfunction

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, check each accepted result transfer
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk) begin
    event_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{event_res, event_tile, tiles_held, bytes_held, frame_hits, frame_misses, last};
      if (pending_events.size() == 0) begin
        report("unexpected result", got, got);
      end else begin
        want = pending_events.pop_front();
        if (got !== want) report("result", got, want);
      end
    end
    if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      run_left <= $urandom_range(0, 40);
      out_stall <= 1'b0;
    end
  end

  // Setup phase and access phase, then an idle bus before the next write
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ROW_WIDTH: sh_width = val[13:0];
      REG_MAX_TILES: sh_max = val[5:0];
      default: sh_budget = val[30:0];
    endcase
    @(posedge clk);
  endtask

  // Wait until every expected result arrived, then let the sequencer settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One command transfer; predicted at the accepting edge
  task automatic send(input cmd_t c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c.cmd; tile_num <= c.tile;
    first_of_frame <= c.first; end_of_frame <= c.endf;
    top_row <= c.top; bottom_row <= c.bot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred_base = pending_events.size();
    predict_command(c);
  endtask

  function automatic cmd_t mk(logic [1:0] cmd, logic [13:0] t, logic f, logic e,
                              logic signed [24:0] tp, logic signed [24:0] bt);
    cmd_t c;
    c.cmd = cmd; c.tile = t; c.first = f; c.endf = e; c.top = tp; c.bot = bt;
    return c;
  endfunction

  // Random command: mostly access sequences over a small tile pool
  function automatic cmd_t rand_cmd(int pool);
    int r = $urandom_range(0, 99);
    logic signed [24:0] tp;
    if (r < 80) begin
      return mk(CMD_ACCESS, (r < 75) ? 14'($urandom_range(0, pool)) : 14'($urandom),
                $urandom_range(0, 7) == 0, $urandom_range(0, 4) == 0,
                25'($urandom), 25'($urandom));
    end
    if (r < 92) begin
      tp = (r < 88) ? 25'($signed($urandom_range(0, pool * TROWS)) - 100) : 25'($urandom);
      return mk(CMD_INVAL, 14'($urandom), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)),
                tp, (r < 88) ? 25'(tp + $urandom_range(0, 3000) - 200) : 25'($urandom));
    end
    if (r < 97) return mk(CMD_CLEAR, 14'($urandom), 1'b1, 1'b1, 25'sd0, 25'sd0);
    return mk(CMD_NONE, 14'($urandom), 1'b1, 1'b1, 25'($urandom), 25'($urandom));
  endfunction

  // Directed rows; rows with a typed answer check it on top of the predictor
  typedef struct {
    cmd_t c;
    bit typed;
    event_t first_ev;
  } row_t;

  initial begin
    row_t rows[$];
    event_t got0;
    sh_width = ROW_WIDTH_RST; sh_max = MAX_TILES_RST; sh_budget = BYTE_BUDGET_RST;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0; sh_tile[i] = '0; sh_stamp[i] = '0;
    end
    sh_use = '0; sh_bytes = '0; sh_hits = '0; sh_misses = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset: first access is a miss of 4 MiB
    rows.push_back('{mk(CMD_ACCESS, 14'd0, 1'b1, 1'b0, 25'sd0, 25'sd0), 1'b1,
                     '{EV_MISS, 14'd0, 6'd1, 31'd4194304, 16'd0, 16'd1, 1'b1}});
    rows.push_back('{mk(CMD_ACCESS, 14'd0, 1'b0, 1'b0, 25'sd0, 25'sd0), 1'b1,
                     '{EV_HIT, 14'd0, 6'd1, 31'd4194304, 16'd1, 16'd1, 1'b1}});
    rows.push_back('{mk(CMD_ACCESS, 14'h3FFF, 1'b0, 1'b0, 25'sd0, 25'sd0), 1'b0, '0});
    rows.push_back('{mk(CMD_ACCESS, 14'h2AAA, 1'b0, 1'b0, 25'sd0, 25'sd0), 1'b0, '0});
    rows.push_back('{mk(CMD_ACCESS, 14'h1555, 1'b0, 1'b1, 25'sd0, 25'sd0), 1'b0, '0});
    // empty range, negative rows, full span
    rows.push_back('{mk(CMD_INVAL, 14'd0, 1'b0, 1'b0, 25'sd100, 25'sd100), 1'b1,
                     '{EV_DONE, 14'd0, 6'd4, 31'd16777216, 16'd1, 16'd4, 1'b1}});
    rows.push_back('{mk(CMD_INVAL, 14'd0, 1'b1, 1'b1, 25'sh1000000, 25'sd1), 1'b0, '0});
    rows.push_back('{mk(CMD_INVAL, 14'd0, 1'b0, 1'b0, 25'sd16777215, 25'sh1000000),
                     1'b0, '0});
    rows.push_back('{mk(CMD_INVAL, 14'd0, 1'b0, 1'b0, 25'sh1000000, 25'sd16777215),
                     1'b0, '0});
    rows.push_back('{mk(CMD_NONE, 14'h3FFF, 1'b1, 1'b1, -25'sd1, -25'sd1), 1'b0, '0});
    rows.push_back('{mk(CMD_CLEAR, 14'd0, 1'b0, 1'b0, 25'sd0, 25'sd0), 1'b1,
                     '{EV_DONE, 14'd0, 6'd0, 31'd0, 16'd0, 16'd0, 1'b1}});
    // fill past the store to force room evictions, then trim at frame end
    for (int i = 0; i < 34; i++)
      rows.push_back('{mk(CMD_ACCESS, 14'(i * 3), i == 0, i == 33, 25'sd0, 25'sd0),
                       1'b0, '0});

    foreach (rows[k]) begin
      send(rows[k].c);
      if (rows[k].typed) begin
        got0 = pending_events[pred_base];
        if (got0 !== rows[k].first_ev) report("typed row", got0, rows[k].first_ev);
      end
    end
    drain();

    // Phases over register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_ROW_WIDTH, 32'd1); write_reg(REG_MAX_TILES, 32'd32);
                 write_reg(REG_BYTE_BUDGET, 32'h4000_0000); end
        1: begin write_reg(REG_ROW_WIDTH, 32'd8192); write_reg(REG_MAX_TILES, 32'd1);
                 write_reg(REG_BYTE_BUDGET, 32'd0); end
        2: write_reg(REG_ROW_WIDTH, 32'd0);           // width out of range
        3: write_reg(REG_ROW_WIDTH, 32'h3FFF);
        4: begin write_reg(REG_ROW_WIDTH, $urandom_range(1, 8192));
                 write_reg(REG_MAX_TILES, $urandom_range(1, 63));
                 write_reg(REG_BYTE_BUDGET, $urandom); end
        default: begin write_reg(REG_ROW_WIDTH, 32'd1024); write_reg(REG_MAX_TILES, 32'd24);
                 write_reg(REG_BYTE_BUDGET, 32'd167772160); end
      endcase
      if (ph == 5) quiet = 1;
      for (int n = 0; n < ((ph >= 4) ? 34 : 12); n++)
        send(rand_cmd((ph == 1) ? 4 : 40));
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
